// ===== hw/rtl/fsif_pkg.sv =====
// fsif_pkg: widths, field codes, kernel tables and the kernel lookup for the
// fractional sample interpolation filter. No dependencies.
`default_nettype none

package fsif_pkg;

  localparam int WIN_W       = 16;
  localparam int TAP_W       = 8;
  localparam int LANES       = 8;
  localparam int PROD_W      = WIN_W + TAP_W;
  localparam int SUM_W       = PROD_W + 3;
  localparam int FRAC_W      = 3;
  localparam int STAGE_W     = 2;
  localparam int OUT_W       = 16;
  localparam int DEPTH_W     = 4;
  localparam int MAX_W       = 12;
  localparam int FILTER_PREC = 6;
  localparam int DEPTH_MIN   = 8;
  localparam int DEPTH_MAX   = 12;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  // stage codes: bit 0 first stage, bit 1 last stage
  localparam logic [STAGE_W-1:0] STAGE_MID   = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_FIRST = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_LAST  = 2'd2;
  localparam logic [STAGE_W-1:0] STAGE_BOTH  = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_DEPTH = 1'b0;
  localparam logic REG_MAX   = 1'b1;

  typedef logic signed [TAP_W-1:0] tap_t;
  typedef tap_t [0:LANES-1]        taps_t;
  typedef tap_t [0:3]              tap4_t;
  typedef tap_t [0:1]              tap2_t;

  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    logic               copy;
  } ctrl_t;

  localparam taps_t LUMA_LONG [4] = '{
    '{ 0, 0,   0, 64,  0,   0, 0,  0},
    '{-1, 4, -10, 57, 19,  -7, 3, -1},
    '{-1, 4, -11, 40, 40, -11, 4, -1},
    '{-1, 3,  -7, 19, 57, -10, 4, -1}
  };

  localparam tap4_t LUMA_SHORT [4] = '{
    '{ 0, 64,  0,  0},
    '{-4, 54, 16, -2},
    '{-4, 36, 36, -4},
    '{-2, 16, 54, -4}
  };

  localparam tap4_t CHROMA_LONG [8] = '{
    '{ 0, 64,  0,  0},
    '{-3, 60,  8, -1},
    '{-4, 54, 16, -2},
    '{-5, 46, 27, -4},
    '{-4, 36, 36, -4},
    '{-4, 27, 46, -5},
    '{-2, 16, 54, -4},
    '{-1,  8, 60, -3}
  };

  localparam tap2_t CHROMA_SHORT [8] = '{
    '{64,  0}, '{56,  8}, '{48, 16}, '{40, 24},
    '{32, 32}, '{24, 40}, '{16, 48}, '{ 8, 56}
  };

  // taps lined up with window positions -3..+4; phase 0 puts 64 on the center
  function automatic taps_t kernel_taps(input logic chroma, input logic shortk,
                                        input logic [FRAC_W-1:0] frac);
    taps_t      k;
    logic [1:0] lf;
    k  = '0;
    lf = frac[1:0];
    if (!chroma && !shortk) begin
      k = LUMA_LONG[lf];
    end else if (!chroma) begin
      for (int i = 0; i < 4; i++) k[2+i] = LUMA_SHORT[lf][i];
    end else if (!shortk) begin
      for (int i = 0; i < 4; i++) k[2+i] = CHROMA_LONG[frac][i];
    end else begin
      k[3] = CHROMA_SHORT[frac][0];
      k[4] = CHROMA_SHORT[frac][1];
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fsif_if.sv =====
// fsif_in_if / fsif_out_if: valid-ready channels for window items and results.
// Depends on fsif_pkg for field widths.
`default_nettype none

interface fsif_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fsif_pkg::WIN_W-1:0]   win_m3;
  logic signed [fsif_pkg::WIN_W-1:0]   win_m2;
  logic signed [fsif_pkg::WIN_W-1:0]   win_m1;
  logic signed [fsif_pkg::WIN_W-1:0]   win_0;
  logic signed [fsif_pkg::WIN_W-1:0]   win_p1;
  logic signed [fsif_pkg::WIN_W-1:0]   win_p2;
  logic signed [fsif_pkg::WIN_W-1:0]   win_p3;
  logic signed [fsif_pkg::WIN_W-1:0]   win_p4;
  logic [fsif_pkg::FRAC_W-1:0]         frac;
  logic                                plane;
  logic                                short_filter;
  logic [fsif_pkg::STAGE_W-1:0]        stage;

  modport source (output valid, win_m3, win_m2, win_m1, win_0, win_p1, win_p2,
                  win_p3, win_p4, frac, plane, short_filter, stage, input ready);
  modport sink   (input valid, win_m3, win_m2, win_m1, win_0, win_p1, win_p2,
                  win_p3, win_p4, frac, plane, short_filter, stage, output ready);
endinterface

interface fsif_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fsif_pkg::OUT_W-1:0] result_sample;

  modport source (output valid, result_sample, input ready);
  modport sink   (input valid, result_sample, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fsif_lane.sv =====
// fsif_lane: one tap lane, registered product of a window sample and its tap.
// Depends on fsif_pkg.
`default_nettype none

module fsif_lane (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [fsif_pkg::WIN_W-1:0]    sample,
  input  wire fsif_pkg::tap_t                       tap,
  output      logic signed [fsif_pkg::PROD_W-1:0]   prod_r
);

  logic signed [fsif_pkg::PROD_W-1:0] prod_nxt;

  assign prod_nxt = fsif_pkg::PROD_W'(sample) * fsif_pkg::PROD_W'(tap);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fsif_merge.sv =====
// fsif_merge: adds the lane products into the registered filter sum.
// Depends on fsif_pkg.
`default_nettype none

module fsif_merge (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [fsif_pkg::PROD_W-1:0]  prod [fsif_pkg::LANES],
  output      logic signed [fsif_pkg::SUM_W-1:0]   sum_r
);

  logic signed [fsif_pkg::SUM_W-1:0] pair [fsif_pkg::LANES/2];
  logic signed [fsif_pkg::SUM_W-1:0] sum_nxt;

  always_comb begin
    for (int i = 0; i < fsif_pkg::LANES/2; i++) begin
      pair[i] = fsif_pkg::SUM_W'(prod[2*i]) + fsif_pkg::SUM_W'(prod[2*i+1]);
    end
    sum_nxt = (pair[0] + pair[1]) + (pair[2] + pair[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fsif_post.sv =====
// fsif_post: scaling, rounding, offset and clipping of the filter sum by stage,
// into the output register. Depends on fsif_pkg.
`default_nettype none

module fsif_post #(
  parameter int INTERNAL_PREC = 14
) (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [fsif_pkg::SUM_W-1:0]    sum,
  input  wire fsif_pkg::ctrl_t                      ctrl,
  input  wire logic [fsif_pkg::DEPTH_W-1:0]         depth,
  input  wire logic [fsif_pkg::MAX_W-1:0]           max_smp,
  output      logic signed [fsif_pkg::OUT_W-1:0]    result_r
);

  localparam int FP   = fsif_pkg::FILTER_PREC;
  localparam int HMAX = INTERNAL_PREC - fsif_pkg::DEPTH_MIN;
  localparam int HW   = $clog2(HMAX + 1);
  localparam int SHW  = $clog2(FP + HMAX + 1);
  localparam int FW   = fsif_pkg::SUM_W + HMAX;
  localparam int LW   = ((fsif_pkg::SUM_W > INTERNAL_PREC + FP) ?
                         fsif_pkg::SUM_W : INTERNAL_PREC + FP) + 2;
  localparam logic [fsif_pkg::OUT_W-1:0] OFFS16 =
    fsif_pkg::OUT_W'(1) << (INTERNAL_PREC - 1);

  logic [fsif_pkg::DEPTH_W-1:0]      d_sat;
  logic [HW-1:0]                     h;
  logic [SHW-1:0]                    sh;
  logic signed [FW-1:0]              f_scaled;
  logic signed [FW-1:0]              f_shift;
  logic [fsif_pkg::OUT_W-1:0]        first_val;
  logic [fsif_pkg::OUT_W-1:0]        mid_val;
  logic signed [LW-1:0]              rnd;
  logic signed [LW-1:0]              acc;
  logic signed [LW-1:0]              lv;
  logic signed [LW-1:0]              max_ext;
  logic [fsif_pkg::OUT_W-1:0]        clip_val;
  logic signed [fsif_pkg::OUT_W-1:0] result_nxt;

  always_comb begin
    if (depth < fsif_pkg::DEPTH_W'(fsif_pkg::DEPTH_MIN)) begin
      d_sat = fsif_pkg::DEPTH_W'(fsif_pkg::DEPTH_MIN);
    end else if (depth > fsif_pkg::DEPTH_W'(fsif_pkg::DEPTH_MAX)) begin
      d_sat = fsif_pkg::DEPTH_W'(fsif_pkg::DEPTH_MAX);
    end else begin
      d_sat = depth;
    end
    h = HW'(INTERNAL_PREC - int'(d_sat));

    mid_val = sum[FP +: fsif_pkg::OUT_W];

    // first stage: floor(sum * 2^h / 2^FP) covers both shift directions
    f_scaled  = FW'(sum);
    f_shift   = (f_scaled <<< h) >>> FP;
    first_val = f_shift[fsif_pkg::OUT_W-1:0] - OFFS16;

    // last stage: round, remove the intermediate offset (not for first-and-last), shift back
    if (ctrl.stage == fsif_pkg::STAGE_BOTH) begin
      rnd = LW'(1) << (FP - 1);
      sh  = SHW'(FP);
    end else begin
      rnd = (LW'(1) << (FP - 1 + int'(h))) + (LW'(1) << (INTERNAL_PREC - 1 + FP));
      sh  = SHW'(FP) + SHW'(h);
    end
    acc     = LW'(sum) + rnd;
    lv      = acc >>> sh;
    max_ext = $signed({{(LW - fsif_pkg::MAX_W){1'b0}}, max_smp});
    if (lv < 0) begin
      clip_val = '0;
    end else if (lv > max_ext) begin
      clip_val = fsif_pkg::OUT_W'(max_smp);
    end else begin
      clip_val = lv[fsif_pkg::OUT_W-1:0];
    end

    case (ctrl.stage)
      fsif_pkg::STAGE_MID:   result_nxt = mid_val;
      fsif_pkg::STAGE_FIRST: result_nxt = first_val;
      fsif_pkg::STAGE_LAST:  result_nxt = clip_val;
      default:               result_nxt = ctrl.copy ? mid_val : clip_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= result_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fractional_sample_interp_filter.sv =====
// Fractional sample interpolation filter: eight-sample window, one result item
// per input item. Depends on fsif_pkg, fsif_if, fsif_lane, fsif_merge, fsif_post.
//
// Takes one window item per clock while the output is not stalled and returns
// one filtered sample per item: eight multiplier lanes form tap products in
// the lane registers, an adder tree sums them in the sum register, and the
// post stage scales, rounds and clips by stage into the output register. Every
// stage holds its item independently, so a stalled output does not keep empty
// stages from filling; with a ready sink the rate is one item per cycle. Phase 0
// runs through the same lanes with a single center tap of 64. Configuration
// is a two-register APB port (bit depth at 0x0, clip maximum at 0x4) and is
// to be written only while no items are in flight.
`default_nettype none

module fractional_sample_interp_filter #(
  parameter int INTERNAL_PREC = 14
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  fsif_in_if.sink                                  in_ch,
  fsif_out_if.source                               out_ch,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [fsif_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [fsif_pkg::CFG_DATA_W-1:0]     pwdata,
  output      logic [fsif_pkg::CFG_DATA_W-1:0]     prdata,
  output      logic                                pready
);

  logic [fsif_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic [fsif_pkg::MAX_W-1:0]   max_r, max_nxt;
  logic                         reg_idx;
  logic                         cfg_wr;

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic en1, en2, en3;
  fsif_pkg::ctrl_t ctrl_in, ctrl1_r, ctrl2_r;
  fsif_pkg::taps_t taps;

  logic signed [fsif_pkg::WIN_W-1:0]  win  [fsif_pkg::LANES];
  logic signed [fsif_pkg::PROD_W-1:0] prod [fsif_pkg::LANES];
  logic signed [fsif_pkg::SUM_W-1:0]  sum;
  logic signed [fsif_pkg::OUT_W-1:0]  result;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    depth_nxt = depth_r;
    max_nxt   = max_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        fsif_pkg::REG_DEPTH: depth_nxt = pwdata[fsif_pkg::DEPTH_W-1:0];
        fsif_pkg::REG_MAX:   max_nxt   = pwdata[fsif_pkg::MAX_W-1:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fsif_pkg::REG_DEPTH:
        prdata = fsif_pkg::CFG_DATA_W'(depth_r);
      fsif_pkg::REG_MAX:
        prdata = fsif_pkg::CFG_DATA_W'(max_r);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= fsif_pkg::DEPTH_W'(8);
      max_r   <= fsif_pkg::MAX_W'(255);
    end else begin
      depth_r <= depth_nxt;
      max_r   <= max_nxt;
    end
  end

  // pipeline flow: a stage moves when it is empty or the next one moves
  assign en3          = !v3_r || out_ch.ready;
  assign en2          = !v2_r || en3;
  assign en1          = !v1_r || en2;
  assign in_ch.ready  = en1;
  assign out_ch.valid = v3_r;

  assign v1_nxt = en1 ? in_ch.valid : v1_r;
  assign v2_nxt = en2 ? v1_r : v2_r;
  assign v3_nxt = en3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_comb begin
    ctrl_in.stage = in_ch.stage;
    ctrl_in.copy  = in_ch.plane ? (in_ch.frac == '0) : (in_ch.frac[1:0] == 2'b00);
    taps          = fsif_pkg::kernel_taps(in_ch.plane, in_ch.short_filter, in_ch.frac);
    win[0] = in_ch.win_m3;
    win[1] = in_ch.win_m2;
    win[2] = in_ch.win_m1;
    win[3] = in_ch.win_0;
    win[4] = in_ch.win_p1;
    win[5] = in_ch.win_p2;
    win[6] = in_ch.win_p3;
    win[7] = in_ch.win_p4;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ctrl1_r <= ctrl_in;
    end
    if (en2) begin
      ctrl2_r <= ctrl1_r;
    end
  end

  for (genvar g = 0; g < fsif_pkg::LANES; g++) begin : g_lane
    fsif_lane u_lane (
      .clk    (clk),
      .en     (en1),
      .sample (win[g]),
      .tap    (taps[g]),
      .prod_r (prod[g])
    );
  end

  fsif_merge u_merge (
    .clk   (clk),
    .en    (en2),
    .prod  (prod),
    .sum_r (sum)
  );

  fsif_post #(
    .INTERNAL_PREC (INTERNAL_PREC)
  ) u_post (
    .clk      (clk),
    .en       (en3),
    .sum      (sum),
    .ctrl     (ctrl2_r),
    .depth    (depth_r),
    .max_smp  (max_r),
    .result_r (result)
  );

  assign out_ch.result_sample = result;

  // a ready sink never holds back the source
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output sink is ready");

  a_accept_lane: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted item missing from lane stage");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v3_r) |-> $past(v2_r))
    else $error("result appeared without an item in the sum stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_ch.ready && v2_r) |=> (v2_r && v3_r))
    else $error("item lost during output stall");

endmodule

`default_nettype wire
